// File: design/qtt_pkg.sv
`timescale 1ns / 1ps
package qtt_pkg;

  localparam int COORD_BITS = 32;
  localparam int FRAC_BITS  = 16;
  localparam int PACK_BITS  = 64;
  localparam int CFG_BITS   = 13;

  localparam int DIFF_BITS = COORD_BITS + 1;
  localparam int PROD_BITS = 2 * DIFF_BITS;
  localparam int SUM_BITS  = PROD_BITS + 2;
  localparam int EDGE_BITS = (COORD_BITS + 2 > CFG_BITS + FRAC_BITS + 1) ?
                             COORD_BITS + 2 : CFG_BITS + FRAC_BITS + 1;

  // Number of register stages inside each test lane.
  localparam int LANE_STAGES = 5;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_BITS-1:0]  diff_t;
  typedef logic signed [PROD_BITS-1:0]  prod_t;
  typedef logic signed [SUM_BITS-1:0]   sum_t;
  typedef logic signed [EDGE_BITS-1:0]  edge_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } pt_t;

  typedef enum logic [1:0] {
    MODE_MOUSE  = 2'd0,
    MODE_EDGE   = 2'd1,
    MODE_TARGET = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  localparam logic [1:0] CFG_STAGE_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_STAGE_HEIGHT = 2'd1;

  localparam diff_t HALF_UNIT = diff_t'(2 ** (FRAC_BITS - 1));

  function automatic sum_t mag(input diff_t v);
    sum_t s;
    s = sum_t'(v);
    return (v < 0) ? -s : s;
  endfunction

endpackage

// File: design/qtt_sat.sv
`timescale 1ns / 1ps
module qtt_sat (
  input  logic                  clk,
  input  qtt_pkg::pt_t [3:0]    own,
  input  qtt_pkg::pt_t          mouse,
  output logic                  hit
);
  import qtt_pkg::*;

  // Stage A: edge normals and the square's bounds.
  diff_t  a_ax [4];
  diff_t  a_ay [4];
  pt_t    a_own [4];
  coord_t a_mx, a_my;
  diff_t  a_mlox, a_mhix, a_mloy, a_mhiy;

  // Stage B: products.
  prod_t  b_px [4][4];
  prod_t  b_py [4][4];
  prod_t  b_cx [4];
  prod_t  b_cy [4];
  sum_t   b_hx [4];
  coord_t b_xmin, b_xmax, b_ymin, b_ymax;
  diff_t  b_mlox, b_mhix, b_mloy, b_mhiy;

  // Stage C: projections.
  sum_t c_proj [4][4];
  sum_t c_slo [4];
  sum_t c_shi [4];
  logic c_sep;

  // Stage D: extents of the own quad.
  sum_t d_lo [4];
  sum_t d_hi [4];
  sum_t d_slo [4];
  sum_t d_shi [4];
  logic d_sep;

  coord_t xmin, xmax, ymin, ymax;
  sum_t   lo_v [4];
  sum_t   hi_v [4];
  logic   sep_any;

  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      a_ax[k]  <= diff_t'(own[k].y) - diff_t'(own[(k + 1) & 3].y);
      a_ay[k]  <= diff_t'(own[(k + 1) & 3].x) - diff_t'(own[k].x);
      a_own[k] <= own[k];
    end
    a_mx   <= mouse.x;
    a_my   <= mouse.y;
    a_mlox <= diff_t'(mouse.x) - HALF_UNIT;
    a_mhix <= diff_t'(mouse.x) + HALF_UNIT;
    a_mloy <= diff_t'(mouse.y) - HALF_UNIT;
    a_mhiy <= diff_t'(mouse.y) + HALF_UNIT;
  end

  always_comb begin
    xmin = a_own[0].x;
    xmax = a_own[0].x;
    ymin = a_own[0].y;
    ymax = a_own[0].y;
    for (int i = 1; i < 4; i++) begin
      if (a_own[i].x < xmin) xmin = a_own[i].x;
      if (a_own[i].x > xmax) xmax = a_own[i].x;
      if (a_own[i].y < ymin) ymin = a_own[i].y;
      if (a_own[i].y > ymax) ymax = a_own[i].y;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      for (int i = 0; i < 4; i++) begin
        b_px[k][i] <= a_own[i].x * a_ax[k];
        b_py[k][i] <= a_own[i].y * a_ay[k];
      end
      b_cx[k] <= a_mx * a_ax[k];
      b_cy[k] <= a_my * a_ay[k];
      // The square's half extent on an axis is half a unit times |ax| + |ay|.
      b_hx[k] <= (mag(a_ax[k]) + mag(a_ay[k])) <<< (FRAC_BITS - 1);
    end
    b_xmin <= xmin;
    b_xmax <= xmax;
    b_ymin <= ymin;
    b_ymax <= ymax;
    b_mlox <= a_mlox;
    b_mhix <= a_mhix;
    b_mloy <= a_mloy;
    b_mhiy <= a_mhiy;
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      for (int i = 0; i < 4; i++) begin
        c_proj[k][i] <= sum_t'(b_px[k][i]) + sum_t'(b_py[k][i]);
      end
      c_slo[k] <= sum_t'(b_cx[k]) + sum_t'(b_cy[k]) - b_hx[k];
      c_shi[k] <= sum_t'(b_cx[k]) + sum_t'(b_cy[k]) + b_hx[k];
    end
    // The square's own axes are the coordinate axes.
    c_sep <= (diff_t'(b_xmax) < b_mlox) || (b_mhix < diff_t'(b_xmin)) ||
             (diff_t'(b_ymax) < b_mloy) || (b_mhiy < diff_t'(b_ymin));
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      lo_v[k] = c_proj[k][0];
      hi_v[k] = c_proj[k][0];
      for (int i = 1; i < 4; i++) begin
        if (c_proj[k][i] < lo_v[k]) lo_v[k] = c_proj[k][i];
        if (c_proj[k][i] > hi_v[k]) hi_v[k] = c_proj[k][i];
      end
    end
  end

  always_ff @(posedge clk) begin
    d_lo  <= lo_v;
    d_hi  <= hi_v;
    d_slo <= c_slo;
    d_shi <= c_shi;
    d_sep <= c_sep;
  end

  always_comb begin
    sep_any = d_sep;
    for (int k = 0; k < 4; k++) begin
      if ((d_hi[k] < d_slo[k]) || (d_shi[k] < d_lo[k])) sep_any = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    hit <= !sep_any;
  end

endmodule

// File: design/qtt_ray.sv
`timescale 1ns / 1ps
module qtt_ray (
  input  logic                  clk,
  input  qtt_pkg::pt_t [3:0]    own,
  input  qtt_pkg::pt_t [3:0]    other,
  output logic                  hit
);
  import qtt_pkg::*;

  // Eight tests: own corners in the target quad, then target corners in the own quad.
  diff_t a_d  [8][4];
  diff_t a_ux [8][4];
  diff_t a_ex [8][4];
  diff_t a_vy [8][4];
  logic  a_st [8][4];

  prod_t b_lhs [8][4];
  prod_t b_rhs [8][4];
  logic  b_st  [8][4];
  logic  b_pos [8][4];

  logic  c_cnt [8][4];
  logic  [7:0] d_in;

  pt_t  q [8][4];
  pt_t  p [8];

  always_comb begin
    for (int c = 0; c < 8; c++) begin
      for (int j = 0; j < 4; j++) begin
        q[c][j] = (c < 4) ? other[j] : own[j];
      end
      p[c] = (c < 4) ? own[c & 3] : other[c & 3];
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 8; c++) begin
      for (int j = 0; j < 4; j++) begin
        a_d[c][j]  <= diff_t'(q[c][(j + 1) & 3].y) - diff_t'(q[c][j].y);
        a_ux[c][j] <= diff_t'(p[c].x) - diff_t'(q[c][j].x);
        a_ex[c][j] <= diff_t'(q[c][(j + 1) & 3].x) - diff_t'(q[c][j].x);
        a_vy[c][j] <= diff_t'(p[c].y) - diff_t'(q[c][j].y);
        a_st[c][j] <= (q[c][j].y > p[c].y) != (q[c][(j + 1) & 3].y > p[c].y);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 8; c++) begin
      for (int j = 0; j < 4; j++) begin
        b_lhs[c][j] <= a_ux[c][j] * a_d[c][j];
        b_rhs[c][j] <= a_ex[c][j] * a_vy[c][j];
        b_st[c][j]  <= a_st[c][j];
        b_pos[c][j] <= a_d[c][j] > 0;
      end
    end
  end

  // The crossing test compares cross-products, flipped when the edge runs downward.
  always_ff @(posedge clk) begin
    for (int c = 0; c < 8; c++) begin
      for (int j = 0; j < 4; j++) begin
        c_cnt[c][j] <= b_st[c][j] &&
                       (b_pos[c][j] ? (b_lhs[c][j] < b_rhs[c][j]) :
                                      (b_rhs[c][j] < b_lhs[c][j]));
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 8; c++) begin
      d_in[c] <= c_cnt[c][0] ^ c_cnt[c][1] ^ c_cnt[c][2] ^ c_cnt[c][3];
    end
  end

  always_ff @(posedge clk) begin
    hit <= |d_in;
  end

endmodule

// File: design/quad_touch_test.sv
`timescale 1ns / 1ps
// Touch test between an own quad and a mouse point, the stage edge or a
// target quad, one query per transaction.
// A query transaction is taken at a rising edge with start high and busy
// low. busy is always low: the pipeline accepts a new query every cycle.
// The answer appears on touching with done high for exactly one cycle,
// in query order. One result per query. Throughput is one query per
// cycle; the latency is set by the input register, five lane stages
// (difference, multiply, sum or compare, reduce, decide) and the
// output register.
// The stage size registers are written through cfg_we, cfg_index and
// cfg_data at any edge with cfg_we high; indexes beyond the list are
// ignored. Write them only while no query is in flight.
// Reset clears the in-flight valid bits and sets the stage to 480 by 360.
// The receiver cannot stall, so results leave on their fixed schedule.
module quad_touch_test (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     mode,
  input  logic [qtt_pkg::PACK_BITS-1:0]  own_v0,
  input  logic [qtt_pkg::PACK_BITS-1:0]  own_v1,
  input  logic [qtt_pkg::PACK_BITS-1:0]  own_v2,
  input  logic [qtt_pkg::PACK_BITS-1:0]  own_v3,
  input  logic [qtt_pkg::PACK_BITS-1:0]  other_v0,
  input  logic [qtt_pkg::PACK_BITS-1:0]  other_v1,
  input  logic [qtt_pkg::PACK_BITS-1:0]  other_v2,
  input  logic [qtt_pkg::PACK_BITS-1:0]  other_v3,
  input  logic [qtt_pkg::PACK_BITS-1:0]  own_position,
  input  logic                           other_visible,
  input  logic                           cfg_we,
  input  logic [1:0]                     cfg_index,
  input  logic [qtt_pkg::CFG_BITS-1:0]   cfg_data,
  output logic                           done,
  output logic                           touching
);
  import qtt_pkg::*;

  logic [CFG_BITS-1:0] stage_width, stage_height;

  logic       s1_valid;
  mode_t      s1_mode;
  logic       s1_vis;
  pt_t [3:0]  s1_own;
  pt_t [3:0]  s1_oth;
  pt_t        s1_pos;

  logic       dl_valid [LANE_STAGES];
  mode_t      dl_mode  [LANE_STAGES];
  logic       dl_vis   [LANE_STAGES];
  logic       dl_edge  [LANE_STAGES];

  edge_t tx, ty, wv, hv;
  logic  edge_hit;
  logic  sat_hit, ray_hit;
  logic  result;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_width  <= CFG_BITS'(480);
      stage_height <= CFG_BITS'(360);
    end else if (cfg_we) begin
      if (cfg_index == CFG_STAGE_WIDTH) stage_width <= cfg_data;
      if (cfg_index == CFG_STAGE_HEIGHT) stage_height <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    s1_mode   <= mode_t'(mode);
    s1_vis    <= other_visible;
    s1_own[0] <= pt_t'(own_v0[2*COORD_BITS-1:0]);
    s1_own[1] <= pt_t'(own_v1[2*COORD_BITS-1:0]);
    s1_own[2] <= pt_t'(own_v2[2*COORD_BITS-1:0]);
    s1_own[3] <= pt_t'(own_v3[2*COORD_BITS-1:0]);
    s1_oth[0] <= pt_t'(other_v0[2*COORD_BITS-1:0]);
    s1_oth[1] <= pt_t'(other_v1[2*COORD_BITS-1:0]);
    s1_oth[2] <= pt_t'(other_v2[2*COORD_BITS-1:0]);
    s1_oth[3] <= pt_t'(other_v3[2*COORD_BITS-1:0]);
    s1_pos    <= pt_t'(own_position[2*COORD_BITS-1:0]);
  end

  // Edge test on doubled position against the full stage size.
  always_comb begin
    tx = edge_t'(s1_pos.x) <<< 1;
    ty = edge_t'(s1_pos.y) <<< 1;
    wv = edge_t'({stage_width, {FRAC_BITS{1'b0}}});
    hv = edge_t'({stage_height, {FRAC_BITS{1'b0}}});
    edge_hit = (tx <= -wv) || (tx >= wv) || (ty <= -hv) || (ty >= hv);
  end

  qtt_sat u_sat (
    .clk   (clk),
    .own   (s1_own),
    .mouse (s1_oth[0]),
    .hit   (sat_hit)
  );

  qtt_ray u_ray (
    .clk   (clk),
    .own   (s1_own),
    .other (s1_oth),
    .hit   (ray_hit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LANE_STAGES; i++) dl_valid[i] <= 1'b0;
    end else begin
      dl_valid[0] <= s1_valid;
      for (int i = 1; i < LANE_STAGES; i++) dl_valid[i] <= dl_valid[i-1];
    end
  end

  always_ff @(posedge clk) begin
    dl_mode[0] <= s1_mode;
    dl_vis[0]  <= s1_vis;
    dl_edge[0] <= edge_hit;
    for (int i = 1; i < LANE_STAGES; i++) begin
      dl_mode[i] <= dl_mode[i-1];
      dl_vis[i]  <= dl_vis[i-1];
      dl_edge[i] <= dl_edge[i-1];
    end
  end

  always_comb begin
    unique case (dl_mode[LANE_STAGES-1])
      MODE_MOUSE:  result = sat_hit;
      MODE_EDGE:   result = dl_edge[LANE_STAGES-1];
      MODE_TARGET: result = dl_vis[LANE_STAGES-1] && ray_hit;
      default:     result = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dl_valid[LANE_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    touching <= result;
  end

endmodule
